// File: hdl/itfe_pkg.sv
// ----------------------------------------------------------------------------
// itfe_pkg: shared types and constants of the tilt front end
// CORDIC angle table, register indexes and the stage data bundle.
// ----------------------------------------------------------------------------
package itfe_pkg;

   localparam int CAL_W    = 41;            // calibrated axis width
   localparam int VEC_W    = CAL_W + 3;     // CORDIC vector, room for growth
   localparam int Z_W      = 34;            // angle accumulator, Q.30
   localparam int MAX_STG  = 24;
   localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   typedef enum logic [2:0] {
      REG_AX_OFF = 3'd0, REG_AY_OFF = 3'd1, REG_AZ_OFF = 3'd2,
      REG_AX_GAIN = 3'd3, REG_AY_GAIN = 3'd4, REG_AZ_GAIN = 3'd5,
      REG_GY_OFF = 3'd6, REG_GZ_OFF = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [Z_W-1:0]   z;
   } vec_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input int i);
      logic signed [Z_W-1:0] t;
      begin
         case (i)
            0: t = 34'sd843314857;
            1: t = 34'sd497837829;
            2: t = 34'sd263043837;
            3: t = 34'sd133525159;
            4: t = 34'sd67021687;
            5: t = 34'sd33543516;
            6: t = 34'sd16775851;
            7: t = 34'sd8388437;
            8: t = 34'sd4194283;
            9: t = 34'sd2097149;
            default: t = Z_W'(64'sd1 << (30 - i));
         endcase
         return t;
      end
   endfunction

endpackage

// File: hdl/itfe_cordic_cell.sv
// ----------------------------------------------------------------------------
// itfe_cordic_cell: one CORDIC vectoring step
// Registered micro-rotation with a fixed shift, plus side payload pass-along.
// ----------------------------------------------------------------------------
module itfe_cordic_cell
   import itfe_pkg::*;
#(
   parameter int SHIFT = 0,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              advance,
   input  vec_type           vec_in,
   input  logic [SIDE_W-1:0] side_in,
   output vec_type           vec_out,
   output logic [SIDE_W-1:0] side_out
);
   vec_type           vec_ff, vec_in_next;
   logic [SIDE_W-1:0] side_ff;
   logic signed [Z_W-1:0] step;

   always_comb begin
      step = atan_q30(SHIFT);
      vec_in_next = vec_in;
      if (vec_in.y > 0) begin
         vec_in_next.x = vec_in.x + (vec_in.y >>> SHIFT);
         vec_in_next.y = vec_in.y - (vec_in.x >>> SHIFT);
         vec_in_next.z = vec_in.z + step;
      end else begin
         vec_in_next.x = vec_in.x - (vec_in.y >>> SHIFT);
         vec_in_next.y = vec_in.y + (vec_in.x >>> SHIFT);
         vec_in_next.z = vec_in.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff  <= vec_in_next;
         side_ff <= side_in;
      end
   end

   assign vec_out  = vec_ff;
   assign side_out = side_ff;
endmodule

// File: hdl/imu_tilt_front_end.sv
// ----------------------------------------------------------------------------
// imu_tilt_front_end: IMU calibration and tilt angle front end
// Calibrates accel/gyro samples and computes roll and pitch by CORDIC atan2.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the pipeline is not stalled; an item
// passes an offset-subtract stage, a gain multiply stage, a pre-rotation stage,
// one cell per CORDIC step for each angle, and an output register. The whole
// pipeline stalls together when the output register is full and not taken.
module imu_tilt_front_end
   import itfe_pkg::*;
#(
   parameter int CORDIC_STAGES   = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_raw_accel_x,
   input  logic signed [15:0] req_raw_accel_y,
   input  logic signed [15:0] req_raw_accel_z,
   input  logic signed [15:0] req_raw_gyro_y,
   input  logic signed [15:0] req_raw_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_roll_angle,
   output logic signed [16:0] rsp_pitch_angle,
   output logic signed [25:0] rsp_roll_rate,
   output logic signed [25:0] rsp_pitch_rate,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   localparam int NSTG  = (CORDIC_STAGES < MAX_STG) ? CORDIC_STAGES : MAX_STG;
   localparam int SH    = 30 - ANGLE_FRAC_BITS;
   localparam int SIDE_W = 53;   // two rates + roll zero flag

   logic signed [23:0] ax_off_ff, ay_off_ff, az_off_ff, gy_off_ff, gz_off_ff;
   logic [15:0]        ax_gain_ff, ay_gain_ff, az_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_off_ff <= '0; ay_off_ff <= '0; az_off_ff <= '0;
         gy_off_ff <= '0; gz_off_ff <= '0;
         ax_gain_ff <= 16'd16384; ay_gain_ff <= 16'd16384;
         az_gain_ff <= 16'd16384;
      end else if (csr_write) begin
         unique case (reg_idx_type'(csr_index))
            REG_AX_OFF:  ax_off_ff  <= csr_wdata;
            REG_AY_OFF:  ay_off_ff  <= csr_wdata;
            REG_AZ_OFF:  az_off_ff  <= csr_wdata;
            REG_AX_GAIN: ax_gain_ff <= csr_wdata[15:0];
            REG_AY_GAIN: ay_gain_ff <= csr_wdata[15:0];
            REG_AZ_GAIN: az_gain_ff <= csr_wdata[15:0];
            REG_GY_OFF:  gy_off_ff  <= csr_wdata;
            REG_GZ_OFF:  gz_off_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global stall: advance whenever output is free or being taken
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: offset subtract
   logic               s1_v_ff;
   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic signed [25:0] rr1_ff, pr1_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (advance) s1_v_ff <= req_valid;
      if (advance) begin
         dx_ff  <= 25'($signed({req_raw_accel_x, 8'd0})) - 25'(ax_off_ff);
         dy_ff  <= 25'($signed({req_raw_accel_y, 8'd0})) - 25'(ay_off_ff);
         dz_ff  <= 25'($signed({req_raw_accel_z, 8'd0})) - 25'(az_off_ff);
         rr1_ff <= 26'(gz_off_ff) - 26'($signed({req_raw_gyro_z, 8'd0}));
         pr1_ff <= 26'(gy_off_ff) - 26'($signed({req_raw_gyro_y, 8'd0}));
      end
   end

   // stage 2: gain multiply
   logic                   s2_v_ff;
   logic signed [CAL_W-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [25:0]     rr2_ff, pr2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (advance) s2_v_ff <= s1_v_ff;
      if (advance) begin
         cx_ff <= CAL_W'(dx_ff) * CAL_W'($signed({1'b0, ax_gain_ff}));
         cy_ff <= CAL_W'(dy_ff) * CAL_W'($signed({1'b0, ay_gain_ff}));
         cz_ff <= CAL_W'(dz_ff) * CAL_W'($signed({1'b0, az_gain_ff}));
         rr2_ff <= rr1_ff;
         pr2_ff <= pr1_ff;
      end
   end

   // stage 3: form vectors, pre-rotate by pi when abscissa negative
   function automatic vec_type pre_rot(input logic signed [CAL_W-1:0] yy,
                                       input logic signed [CAL_W-1:0] xx);
      vec_type v;
      begin
         v.x = VEC_W'(xx);
         v.y = VEC_W'(yy);
         v.z = '0;
         if (xx < 0) begin
            v.z = (yy >= 0) ? PI_Q30 : -PI_Q30;
            v.x = -VEC_W'(xx);
            v.y = -VEC_W'(yy);
         end
         return v;
      end
   endfunction

   vec_type           roll_c [NSTG+1];
   vec_type           pitch_c[NSTG+1];
   logic [SIDE_W-1:0] side_c [NSTG+1];
   logic              pzero_c[NSTG+1];
   logic              s3_v_ff;
   vec_type           roll0_ff, pitch0_ff;
   logic [SIDE_W-1:0] side0_ff;
   logic              pzero0_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (advance) s3_v_ff <= s2_v_ff;
      if (advance) begin
         roll0_ff  <= pre_rot(-cx_ff, cy_ff);
         pitch0_ff <= pre_rot(-cx_ff, -cz_ff);
         // bit 0 flags the roll zero vector
         side0_ff  <= {rr2_ff, pr2_ff, (cx_ff == '0) && (cy_ff == '0)};
         pzero0_ff <= (cx_ff == '0) && (cz_ff == '0);
      end
   end
   assign roll_c[0]  = roll0_ff;
   assign pitch_c[0] = pitch0_ff;
   assign side_c[0]  = side0_ff;
   assign pzero_c[0] = pzero0_ff;

   for (genvar g = 0; g < NSTG; g++) begin : g_cell
      itfe_cordic_cell #(.SHIFT(g), .SIDE_W(SIDE_W)) u_roll (
         .clock(clock), .advance(advance),
         .vec_in(roll_c[g]), .side_in(side_c[g]),
         .vec_out(roll_c[g+1]), .side_out(side_c[g+1]));
      itfe_cordic_cell #(.SHIFT(g), .SIDE_W(1)) u_pitch (
         .clock(clock), .advance(advance),
         .vec_in(pitch_c[g]), .side_in(pzero_c[g]),
         .vec_out(pitch_c[g+1]), .side_out(pzero_c[g+1]));
   end

   // valid flags travel beside the cells in a reset shift line
   logic [NSTG-1:0] vchain_ff;
   always_ff @(posedge clock) begin
      if (reset) vchain_ff <= '0;
      else if (advance)
         vchain_ff <= {vchain_ff[NSTG-2:0], s3_v_ff};
   end

   function automatic logic [16:0] ang_out(input logic signed [Z_W-1:0] z,
                                           input logic zero);
      logic signed [Z_W:0] v;
      begin
         v = (zero ? (Z_W+1)'(0) : (Z_W+1)'(z)) - (Z_W+1)'(HALF_PI_Q30)
             + ((Z_W+1)'(1) <<< (SH - 1));
         return 17'(v >>> SH);
      end
   endfunction

   logic               out_v_ff;
   logic signed [16:0] roll_ff, pitch_ff;
   logic signed [25:0] rr_ff, pr_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= vchain_ff[NSTG-1];
      if (advance) begin
         roll_ff  <= ang_out(roll_c[NSTG].z, side_c[NSTG][0]);
         pitch_ff <= ang_out(pitch_c[NSTG].z, pzero_c[NSTG]);
         rr_ff    <= side_c[NSTG][52:27];
         pr_ff    <= side_c[NSTG][26:1];
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_rate   = rr_ff;
   assign rsp_pitch_rate  = pr_ff;

   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll_angle);
   endproperty
   a_hold: assert property (p_hold) else $error("result dropped");

   property p_stall;
      @(posedge clock) disable iff (reset)
         !advance |=> $stable(vchain_ff);
   endproperty
   a_stall: assert property (p_stall) else $error("chain moved on stall");

   property p_ready;
      @(posedge clock) disable iff (reset)
         !rsp_valid |-> req_ready;
   endproperty
   a_ready: assert property (p_ready) else $error("ready low while empty");
endmodule

// File: bench/tilt_checker.sv
// ----------------------------------------------------------------------------
// tilt_checker: result predictor and scoreboard for the tilt front end
// Mirrors the register writes, computes calibrated axes, CORDIC atan2 angles
// and gyro rates for each accepted item, and compares every result in order.
// ----------------------------------------------------------------------------
module tilt_checker
   import itfe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_raw_accel_x,
   input  logic signed [15:0] req_raw_accel_y,
   input  logic signed [15:0] req_raw_accel_z,
   input  logic signed [15:0] req_raw_gyro_y,
   input  logic signed [15:0] req_raw_gyro_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [16:0] rsp_roll_angle,
   input  logic signed [16:0] rsp_pitch_angle,
   input  logic signed [25:0] rsp_roll_rate,
   input  logic signed [25:0] rsp_pitch_rate,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic signed [16:0] roll;
      logic signed [16:0] pitch;
      logic signed [25:0] roll_rate;
      logic signed [25:0] pitch_rate;
   } tilt_result_type;

   localparam int STAGES = 16;
   localparam int FRAC   = 13;

   logic signed [23:0] offset_q[8];
   logic [15:0]        gain_q[8];
   tilt_result_type    expected_q[$];

   assign pending = expected_q.size();

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_angle(longint yy, longint xx);
      longint z, dx, dy, t;
      z = 0;
      if (xx == 0 && yy == 0) return 0;
      if (xx < 0) begin
         z = (yy >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
         xx = -xx;
         yy = -yy;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = floor_shift(yy, i);
         dy = floor_shift(xx, i);
         if (i < 10) begin
            case (i)
               0: t = 843314857;  1: t = 497837829;  2: t = 263043837;
               3: t = 133525159;  4: t = 67021687;   5: t = 33543516;
               6: t = 16775851;   7: t = 8388437;    8: t = 4194283;
               default: t = 2097149;
            endcase
         end else begin
            t = longint'(1) << (30 - i);
         end
         if (yy > 0) begin
            xx += dx;
            yy -= dy;
            z += t;
         end else begin
            xx -= dx;
            yy += dy;
            z -= t;
         end
      end
      return z;
   endfunction

   function automatic logic signed [16:0] angle_q13(longint z);
      longint v;
      v = z - longint'(HALF_PI_Q30) + (longint'(1) << (30 - FRAC - 1));
      return 17'(floor_shift(v, 30 - FRAC));
   endfunction

   function automatic longint calibrate(logic signed [15:0] raw, int axis);
      longint d;
      d = longint'(raw) * 256 - longint'(offset_q[axis]);
      return d * longint'({1'b0, gain_q[axis + 3]});
   endfunction

   always @(posedge clock) begin
      longint ax, ay, az;
      tilt_result_type e, got;
      if (reset) begin
         foreach (offset_q[i]) offset_q[i] <= '0;
         foreach (gain_q[i]) gain_q[i] <= 16'd16384;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index inside {REG_AX_GAIN, REG_AY_GAIN, REG_AZ_GAIN})
               gain_q[csr_index] <= csr_wdata[15:0];
            else
               offset_q[csr_index] <= csr_wdata;
         end
         if (req_valid && req_ready) begin
            ax = calibrate(req_raw_accel_x, 0);
            ay = calibrate(req_raw_accel_y, 1);
            az = calibrate(req_raw_accel_z, 2);
            e.roll = angle_q13(cordic_angle(-ax, ay));
            e.pitch = angle_q13(cordic_angle(-ax, -az));
            e.roll_rate = 26'(longint'(offset_q[REG_GZ_OFF])
                              - longint'(req_raw_gyro_z) * 256);
            e.pitch_rate = 26'(longint'(offset_q[REG_GY_OFF])
                               - longint'(req_raw_gyro_y) * 256);
            expected_q.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_roll_angle, rsp_pitch_angle, rsp_roll_rate, rsp_pitch_rate};
            if (expected_q.size() == 0) begin
               $error("unexpected result item");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (got != e) fail_count <= fail_count + 1;
               if (got.roll != e.roll)
                  $error("roll_angle: expected %0d, got %0d", e.roll, got.roll);
               if (got.pitch != e.pitch)
                  $error("pitch_angle: expected %0d, got %0d", e.pitch, got.pitch);
               if (got.roll_rate != e.roll_rate)
                  $error("roll_rate: expected %0d, got %0d", e.roll_rate,
                         got.roll_rate);
               if (got.pitch_rate != e.pitch_rate)
                  $error("pitch_rate: expected %0d, got %0d", e.pitch_rate,
                         got.pitch_rate);
            end
         end
      end
   end

endmodule

// File: bench/tb_imu_tilt_front_end.sv
// ----------------------------------------------------------------------------
// tb_imu_tilt_front_end: testbench top for the tilt front end
// Drives directed and random sensor items under several calibration settings
// with random gaps on both channels; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_imu_tilt_front_end;
   import itfe_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_raw_accel_x = '0;
   logic signed [15:0] req_raw_accel_y = '0;
   logic signed [15:0] req_raw_accel_z = '0;
   logic signed [15:0] req_raw_gyro_y = '0;
   logic signed [15:0] req_raw_gyro_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_roll_angle;
   logic signed [16:0] rsp_pitch_angle;
   logic signed [25:0] rsp_roll_rate;
   logic signed [25:0] rsp_pitch_rate;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;
   int                 fail_count;
   int                 pending;
   logic               stim_done = 1'b0;
   int                 stall_left = 0;

   always #2 clock = ~clock;

   imu_tilt_front_end i_dut (.*);

   tilt_checker i_checker (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // hold the write strobe high; the caller drops it after the last write
   task automatic write_reg(reg_idx_type idx, logic [23:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // keep valid high into the next item when no gap follows
   task automatic send_sample(logic signed [15:0] ax, ay, az, gy, gz);
      int gap;
      req_valid <= 1'b1;
      req_raw_accel_x <= ax;
      req_raw_accel_y <= ay;
      req_raw_accel_z <= az;
      req_raw_gyro_y <= gy;
      req_raw_gyro_z <= gz;
      do @(posedge clock); while (!req_ready);
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   // hold ready low for random stretches, mostly short and a few long
   always @(posedge clock) begin
      if (stim_done) rsp_ready <= 1'b1;
      else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= gap_length();
      end else rsp_ready <= 1'b1;
   end

   initial begin
      logic signed [15:0] x;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero vector, axis crossings
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd100, 16'sd100, -16'sd1, 16'sd1);
      send_sample(16'sd0, -16'sd100, -16'sd100, 16'sd1, -16'sd1);
      send_sample(16'sd100, 16'sd0, 16'sd0, 16'sh5555, 16'shaaaa);
      send_sample(-16'sd100, 16'sd0, 16'sd0, 16'shaaaa, 16'sh5555);
      send_sample(16'sd50, 16'sd50, -16'sd50, 16'sd3, -16'sd3);
      send_sample(-16'sd50, -16'sd50, 16'sd50, 16'sd7, 16'sd9);
      send_sample(16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         repeat (30) @(posedge clock);
         for (int r = 0; r < 8; r++) begin
            logic [23:0] v;
            case (phase)
               0: v = (r >= 3 && r <= 5) ? 24'd16384 : 24'd0;
               1: v = (r >= 3 && r <= 5) ? 24'd0 : 24'h7fffff;
               2: v = (r >= 3 && r <= 5) ? 24'd65535 : 24'h800000;
               default: v = 24'($urandom);
            endcase
            write_reg(reg_idx_type'(r), v);
         end
         csr_write <= 1'b0;
         if (phase == 1) send_sample(16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
         for (int n = 0; n < 280; n++) begin
            x = pick_sample();
            send_sample(x, pick_sample(), pick_sample(), 16'($urandom),
                        16'($urandom));
         end
         drain();
      end
      stim_done <= 1'b1;
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
